[hw/rtl/rcfd_pkg.sv]
// Package for the RC channel frame decoder: frame constants, the job type that
// passes from the front part to the back part, and the channel extraction helper.
// No dependencies.
`default_nettype none

package rcfd_pkg;

    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned CH_W         = 11;
    localparam int unsigned NUM_CH       = 16;
    localparam int unsigned CH_IDX_W     = 4;
    localparam int unsigned NUM_AUX      = 8;
    localparam int unsigned AUX_FIRST_CH = 4;
    localparam int unsigned STORED       = 23;
    localparam int unsigned DATA_BYTES   = 22;
    localparam int unsigned STICK_BYTES  = 6;
    localparam int unsigned DATA_W       = DATA_BYTES * BYTE_W;
    localparam int unsigned STORE_W      = STORED * BYTE_W;
    localparam int unsigned STICK_W      = STICK_BYTES * BYTE_W;
    localparam int unsigned POS_W        = 5;
    localparam int unsigned QUEUE_DEPTH  = 2;
    localparam int unsigned QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [BYTE_W-1:0]   START_BYTE    = 8'h0F;
    localparam logic [BYTE_W-1:0]   END_BYTE      = 8'h00;
    localparam logic [POS_W-1:0]    POS_IDLE      = 5'd0;
    localparam logic [POS_W-1:0]    POS_END       = 5'd24;
    localparam logic [CH_W-1:0]     THRESH_RESET  = 11'd1000;
    localparam logic [CH_IDX_W-1:0] LAST_CH       = 4'd15;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_SYNC = 1'b1;

    typedef struct packed {
        logic                 sync_err;
        logic [BYTE_W-1:0]    flags;
        logic [NUM_AUX-1:0]   aux;
        logic [DATA_W-1:0]    data;
    } frame_job_t;

    // Channel k occupies bits 11k..11k+10 of the little-endian data bytes.
    function automatic logic [CH_W-1:0] channel_of(input logic [DATA_W-1:0] data,
                                                   input int unsigned k);
        channel_of = data[CH_W*k +: CH_W];
    endfunction

endpackage

`default_nettype wire

[hw/rtl/rcfd_front.sv]
// Front part of the frame decoder: tracks the frame position, collects the
// frame bytes, checks the end byte and pushes one job per frame into the queue.
// Depends on rcfd_pkg.
`default_nettype none

module rcfd_front (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_valid,
    output logic                           s_ready,
    input  wire  [rcfd_pkg::BYTE_W-1:0]    s_rx_byte,
    input  wire                            cfg_wr_en,
    input  wire  [rcfd_pkg::CH_W-1:0]      cfg_wr_data,
    input  wire                            push_ready,
    output logic                           push_valid,
    output rcfd_pkg::frame_job_t           push_job
);

    logic [rcfd_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [rcfd_pkg::STORE_W-1:0] bytes_reg;
    logic [rcfd_pkg::CH_W-1:0]    thresh_reg;
    logic                         accept;
    logic [rcfd_pkg::NUM_AUX-1:0] aux;

    // The input only stalls on the end byte, when the queue has no room for the job.
    assign s_ready = (pos_reg != rcfd_pkg::POS_END) || push_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        pos_next = pos_reg;
        if (accept) begin
            if (pos_reg == rcfd_pkg::POS_IDLE) begin
                pos_next = (s_rx_byte == rcfd_pkg::START_BYTE) ? 5'd1 : rcfd_pkg::POS_IDLE;
            end else if (pos_reg == rcfd_pkg::POS_END) begin
                pos_next = rcfd_pkg::POS_IDLE;
            end else begin
                pos_next = pos_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= rcfd_pkg::POS_IDLE;
            thresh_reg <= rcfd_pkg::THRESH_RESET;
        end else begin
            pos_reg <= pos_next;
            if (cfg_wr_en) begin
                thresh_reg <= cfg_wr_data;
            end
        end
    end

    // Data bytes shift in from the top, so once the frame is complete byte 1
    // sits in the low eight bits and the flag byte in the top eight.
    always_ff @(posedge aclk) begin
        if (accept && (pos_reg != rcfd_pkg::POS_IDLE) && (pos_reg != rcfd_pkg::POS_END)) begin
            bytes_reg <= {s_rx_byte, bytes_reg[rcfd_pkg::STORE_W-1:rcfd_pkg::BYTE_W]};
        end
    end

    always_comb begin
        for (int i = 0; i < rcfd_pkg::NUM_AUX; i++) begin
            aux[i] = rcfd_pkg::channel_of(bytes_reg[rcfd_pkg::DATA_W-1:0],
                                          rcfd_pkg::AUX_FIRST_CH + i) > thresh_reg;
        end
    end

    assign push_valid        = accept && (pos_reg == rcfd_pkg::POS_END);
    assign push_job.sync_err = (s_rx_byte != rcfd_pkg::END_BYTE);
    assign push_job.flags    = bytes_reg[rcfd_pkg::STORE_W-1:rcfd_pkg::DATA_W];
    assign push_job.aux      = aux;
    assign push_job.data     = bytes_reg[rcfd_pkg::DATA_W-1:0];

endmodule

`default_nettype wire

[hw/rtl/rcfd_queue.sv]
// Short register queue of frame jobs between the front and back parts.
// Depends on rcfd_pkg.
`default_nettype none

module rcfd_queue (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    push_valid,
    output logic                   push_ready,
    input  rcfd_pkg::frame_job_t   push_job,
    output logic                   pop_valid,
    input  wire                    pop_ready,
    output rcfd_pkg::frame_job_t   pop_job
);

    rcfd_pkg::frame_job_t              entries_reg [rcfd_pkg::QUEUE_DEPTH];
    logic [rcfd_pkg::QPTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [rcfd_pkg::QCNT_W-1:0]       count_reg, count_next;
    logic                              do_push, do_pop;

    localparam logic [rcfd_pkg::QPTR_W-1:0] PTR_LAST = rcfd_pkg::QPTR_W'(rcfd_pkg::QUEUE_DEPTH - 1);
    localparam logic [rcfd_pkg::QCNT_W-1:0] CNT_FULL = rcfd_pkg::QCNT_W'(rcfd_pkg::QUEUE_DEPTH);

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_job    = entries_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/rcfd_back.sv]
// Back part of the frame decoder: walks the channels of the job at the head of
// the queue; while m_ready holds, one result per cycle leaves the output register.
// Depends on rcfd_pkg.
`default_nettype none

module rcfd_back (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               job_valid,
    output logic                              job_ready,
    input  rcfd_pkg::frame_job_t              job,
    output logic                              m_valid,
    input  wire                               m_ready,
    output logic                              m_status,
    output logic [rcfd_pkg::CH_IDX_W-1:0]     m_channel_index,
    output logic [rcfd_pkg::CH_W-1:0]         m_channel_value,
    output logic [rcfd_pkg::STICK_W-1:0]      m_stick_bytes,
    output logic [rcfd_pkg::NUM_AUX-1:0]      m_aux_bits,
    output logic [rcfd_pkg::BYTE_W-1:0]       m_flag_bits,
    output logic                              m_last
);

    logic                              m_valid_reg;
    logic                              status_reg;
    logic [rcfd_pkg::CH_IDX_W-1:0]     index_reg;
    logic [rcfd_pkg::CH_W-1:0]         value_reg;
    logic [rcfd_pkg::STICK_W-1:0]      stick_reg;
    logic [rcfd_pkg::NUM_AUX-1:0]      aux_reg;
    logic [rcfd_pkg::BYTE_W-1:0]       flag_reg;
    logic                              last_reg;
    logic [rcfd_pkg::CH_IDX_W-1:0]     ch_cnt_reg;
    logic [rcfd_pkg::CH_W-1:0]         channels [rcfd_pkg::NUM_CH];
    logic                              load;
    logic                              job_done;

    always_comb begin
        for (int k = 0; k < rcfd_pkg::NUM_CH; k++) begin
            channels[k] = rcfd_pkg::channel_of(job.data, k);
        end
    end

    assign load      = job_valid && (!m_valid_reg || m_ready);
    // A sync-error job yields a single result; a good frame yields one per channel.
    assign job_done  = job.sync_err || (ch_cnt_reg == rcfd_pkg::LAST_CH);
    assign job_ready = load && job_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            ch_cnt_reg  <= '0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
                ch_cnt_reg  <= job_done ? '0 : ch_cnt_reg + 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            if (job.sync_err) begin
                status_reg <= rcfd_pkg::STATUS_SYNC;
                index_reg  <= '0;
                value_reg  <= '0;
                stick_reg  <= '0;
                aux_reg    <= '0;
                flag_reg   <= '0;
                last_reg   <= 1'b1;
            end else begin
                status_reg <= rcfd_pkg::STATUS_OK;
                index_reg  <= ch_cnt_reg;
                value_reg  <= channels[ch_cnt_reg];
                stick_reg  <= job.data[rcfd_pkg::STICK_W-1:0];
                aux_reg    <= job.aux;
                flag_reg   <= job.flags;
                last_reg   <= (ch_cnt_reg == rcfd_pkg::LAST_CH);
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_channel_index = index_reg;
    assign m_channel_value = value_reg;
    assign m_stick_bytes   = stick_reg;
    assign m_aux_bits      = aux_reg;
    assign m_flag_bits     = flag_reg;
    assign m_last          = last_reg;

endmodule

`default_nettype wire

[hw/rtl/rc_channel_frame_decoder_core.sv]
// RC channel frame decoder. Received bytes are taken at one per cycle; the
// input stalls only on the end byte of a frame, and only while the two-entry
// job queue already holds two decoded frames. A good 25-byte frame yields
// sixteen results, one per cycle while the output is taken, and a frame with
// a bad end byte yields a single sync-error result; the output register sets
// the result rate. The user must write the auxiliary threshold through
// cfg_wr_en and cfg_wr_data only while no frame is in flight (unenforced).
// Depends on rcfd_pkg, rcfd_front, rcfd_queue and rcfd_back.
`default_nettype none

module rc_channel_frame_decoder_core (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_valid,
    output logic                              s_ready,
    input  wire  [rcfd_pkg::BYTE_W-1:0]       s_rx_byte,
    input  wire                               cfg_wr_en,
    input  wire  [rcfd_pkg::CH_W-1:0]         cfg_wr_data,
    output logic                              m_valid,
    input  wire                               m_ready,
    output logic                              m_status,
    output logic [rcfd_pkg::CH_IDX_W-1:0]     m_channel_index,
    output logic [rcfd_pkg::CH_W-1:0]         m_channel_value,
    output logic [rcfd_pkg::STICK_W-1:0]      m_stick_bytes,
    output logic [rcfd_pkg::NUM_AUX-1:0]      m_aux_bits,
    output logic [rcfd_pkg::BYTE_W-1:0]       m_flag_bits,
    output logic                              m_last
);

    logic                   push_valid, push_ready;
    logic                   pop_valid, pop_ready;
    rcfd_pkg::frame_job_t   push_job, pop_job;

    rcfd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_rx_byte   (s_rx_byte),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .push_ready  (push_ready),
        .push_valid  (push_valid),
        .push_job    (push_job)
    );

    rcfd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    rcfd_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .job_valid       (pop_valid),
        .job_ready       (pop_ready),
        .job             (pop_job),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_channel_index (m_channel_index),
        .m_channel_value (m_channel_value),
        .m_stick_bytes   (m_stick_bytes),
        .m_aux_bits      (m_aux_bits),
        .m_flag_bits     (m_flag_bits),
        .m_last          (m_last)
    );

endmodule

`default_nettype wire
